[sv/aoc_pkg.sv]
// ---------------------------------------------------------------------------
// Alpha-over compositor package
// Shared widths and constants for the straight-alpha "over" compositor.
// ---------------------------------------------------------------------------
package aoc_pkg;

   localparam int ChanW  = 8;                  // color and alpha width
   localparam int WgtW   = 2 * ChanW;          // weight and denominator width
   localparam int NumW   = ChanW + WgtW;       // weighted sum width
   localparam int QuoW   = ChanW;              // every quotient fits a channel
   localparam int Latency = 13;                // accept edge to strobe edge

   localparam logic [ChanW-1:0] AlphaMaxReset = 8'd255;

   typedef logic [ChanW-1:0] chan_type;
   typedef logic [WgtW-1:0]  wgt_type;
   typedef logic [NumW-1:0]  num_type;

endpackage

[sv/aoc_div_pipe.sv]
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage; the quotient is known to fit in QuoW
// bits. A new division enters every cycle.
// ---------------------------------------------------------------------------
module aoc_div_pipe (
   input  logic               clock,
   input  aoc_pkg::num_type   num_in,
   input  aoc_pkg::wgt_type   dvs_in,
   output logic [aoc_pkg::QuoW-1:0] quo_out
);
   import aoc_pkg::*;

   num_type              rem_ff [1:QuoW];
   wgt_type              dvs_ff [1:QuoW];
   logic [QuoW-1:0]      quo_ff [1:QuoW];

   for (genvar j = 0; j < QuoW; j++) begin : g_step
      localparam int Bit = QuoW - 1 - j;
      num_type         rem_s;
      wgt_type         dvs_s;
      logic [QuoW-1:0] quo_s;
      num_type         sh_in;
      logic            take_in;

      // The first stage works on the incoming operands directly.
      if (j == 0) begin : g_first
         assign rem_s = num_in;
         assign dvs_s = dvs_in;
         assign quo_s = '0;
      end else begin : g_rest
         assign rem_s = rem_ff[j];
         assign dvs_s = dvs_ff[j];
         assign quo_s = quo_ff[j];
      end

      assign sh_in   = NumW'(dvs_s) << Bit;
      assign take_in = (rem_s >= sh_in);

      always_ff @(posedge clock) begin
         rem_ff[j+1] <= take_in ? (rem_s - sh_in) : rem_s;
         dvs_ff[j+1] <= dvs_s;
         quo_ff[j+1] <= quo_s | (take_in ? (QuoW'(1) << Bit) : '0);
      end
   end

   assign quo_out = quo_ff[QuoW];

endmodule

[sv/alpha_over_composite.sv]
// ---------------------------------------------------------------------------
// Alpha-over compositor
// Porter-Duff "over" of a straight-alpha foreground pixel onto a background.
// ---------------------------------------------------------------------------
// A word accepted on start passes the capture, weight, product and
// numerator stages, the dividers and the output register, with rsp_valid.
// Throughput: one word per cycle; busy is always low, because each of the
// four 8-stage dividers takes a new division every cycle.
// Reset (synchronous, active high) empties the pipeline and sets alpha_max
// to 255. The receiver cannot stall, so the pipeline never holds.
module alpha_over_composite (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  aoc_pkg::chan_type req_fg_red,
   input  aoc_pkg::chan_type req_fg_green,
   input  aoc_pkg::chan_type req_fg_blue,
   input  aoc_pkg::chan_type req_fg_alpha,
   input  aoc_pkg::chan_type req_bg_red,
   input  aoc_pkg::chan_type req_bg_green,
   input  aoc_pkg::chan_type req_bg_blue,
   input  aoc_pkg::chan_type req_bg_alpha,
   output logic             rsp_valid,
   output aoc_pkg::chan_type rsp_out_red,
   output aoc_pkg::chan_type rsp_out_green,
   output aoc_pkg::chan_type rsp_out_blue,
   output aoc_pkg::chan_type rsp_out_alpha,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  aoc_pkg::chan_type csr_wdata
);
   import aoc_pkg::*;

   localparam int DivLanes = 4;   // three colors and the output alpha

   // The alpha_max register. It may be written at any time.
   chan_type amax_ff;
   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         amax_ff <= AlphaMaxReset;
      end else if (csr_valid && csr_ready) begin
         amax_ff <= csr_wdata;
      end
   end

   // Valid bits travel alongside the data, one per stage.
   logic [Latency-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Latency-2:0], start && !busy};
      end
   end
   assign rsp_valid = vld_ff[Latency-1];

   // Stage 0: capture the word and clamp both alphas to alpha_max.
   chan_type cf0_ff [0:2];
   chan_type cb0_ff [0:2];
   chan_type a0_ff, b0_ff, m0_ff;
   always_ff @(posedge clock) begin
      cf0_ff[0] <= req_fg_red;
      cf0_ff[1] <= req_fg_green;
      cf0_ff[2] <= req_fg_blue;
      cb0_ff[0] <= req_bg_red;
      cb0_ff[1] <= req_bg_green;
      cb0_ff[2] <= req_bg_blue;
      a0_ff     <= (req_fg_alpha > amax_ff) ? amax_ff : req_fg_alpha;
      b0_ff     <= (req_bg_alpha > amax_ff) ? amax_ff : req_bg_alpha;
      m0_ff     <= amax_ff;
   end

   // Stage 1: the two weights, wf = A*M and wb = B*(M-A).
   chan_type cf1_ff [0:2];
   chan_type cb1_ff [0:2];
   wgt_type  wf1_ff, wb1_ff;
   chan_type m1_ff;
   always_ff @(posedge clock) begin
      cf1_ff <= cf0_ff;
      cb1_ff <= cb0_ff;
      wf1_ff <= WgtW'(a0_ff) * WgtW'(m0_ff);
      wb1_ff <= WgtW'(b0_ff) * WgtW'(m0_ff - a0_ff);
      m1_ff  <= m0_ff;
   end

   // Stage 2: weighted color products and the denominator. The sum of the
   // weights never exceeds M*M, so it fits the weight width.
   num_type  pf2_ff [0:2];
   num_type  pb2_ff [0:2];
   wgt_type  den2_ff;
   chan_type m2_ff;
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         pf2_ff[c] <= NumW'(cf1_ff[c]) * NumW'(wf1_ff);
         pb2_ff[c] <= NumW'(cb1_ff[c]) * NumW'(wb1_ff);
      end
      den2_ff <= WgtW'(wf1_ff + wb1_ff);
      m2_ff   <= m1_ff;
   end

   // Stage 3: numerators and the zero flag. Both alphas zero (and so also a
   // zero alpha_max) shows as a zero denominator.
   num_type  num3_ff [0:DivLanes-1];
   wgt_type  dvs3_ff [0:DivLanes-1];
   logic     zero3_ff;
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         num3_ff[c] <= pf2_ff[c] + pb2_ff[c];
         dvs3_ff[c] <= den2_ff;
      end
      // The output alpha is D / M, and D <= M*M keeps it below 256.
      num3_ff[3] <= NumW'(den2_ff);
      dvs3_ff[3] <= WgtW'(m2_ff);
      zero3_ff   <= (den2_ff == '0);
   end

   // Dividers: one quotient bit per stage. A weighted mean of two 8-bit
   // values never exceeds 255, so no saturation is needed.
   logic [QuoW-1:0] quo [0:DivLanes-1];
   for (genvar l = 0; l < DivLanes; l++) begin : g_div
      aoc_div_pipe u_div (
         .clock   (clock),
         .num_in  (num3_ff[l]),
         .dvs_in  (dvs3_ff[l]),
         .quo_out (quo[l])
      );
   end

   // The zero flag is delayed to line up with the quotients.
   logic [QuoW-1:0] zero_ff;
   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[QuoW-2:0], zero3_ff};
   end

   // Output register: a zero denominator forces the whole result to zero.
   chan_type out_ff [0:DivLanes-1];
   always_ff @(posedge clock) begin
      for (int l = 0; l < DivLanes; l++) begin
         out_ff[l] <= zero_ff[QuoW-1] ? '0 : ChanW'(quo[l]);
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_alpha = out_ff[3];

endmodule

[sv/aoc_checker.sv]
// ---------------------------------------------------------------------------
// Alpha-over compositor port checker
// Watches the top-level ports for pipeline timing and handshake behavior.
// ---------------------------------------------------------------------------
module aoc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);
   import aoc_pkg::*;

   // The compositor takes a word every cycle.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy went high");

   // Every accepted word yields exactly one strobe at fixed latency.
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(Latency) rsp_valid)
      else $error("result strobe missing after accepted word");

   a_bwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result strobe without an accepted word");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind alpha_over_composite aoc_checker u_aoc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_ready (csr_ready)
);
